FILE: hdl/pcxrle_pkg.sv
package pcxrle_pkg;

  localparam logic [7:0] MARKER_BASE = 8'hC0;
  localparam logic [7:0] COUNT_MASK  = 8'h3F;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_STRIDE = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic [7:0] coded_byte;
    logic       start_of_image;
    logic       end_of_data;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] pixel_value;
    logic       last_of_burst;
    logic       image_complete;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic decide;
    logic step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cfg_busy;
    logic dec_emit;
    logic step_blocked;
    logic step_final;
  } sts_t;

endpackage

FILE: hdl/pcxrle_ctrl.sv
module pcxrle_ctrl
  import pcxrle_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DECIDE = 3'b010,
    S_EMIT   = 3'b100
  } state_t;

  state_t state, state_next;

  assign in_ready   = (state == S_IDLE) && !sts.cfg_busy;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.decide = (state == S_DECIDE);
  assign cmd.step   = (state == S_EMIT) && !sts.step_blocked;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.accept) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        state_next = sts.dec_emit ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (cmd.step && sts.step_final) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hdl/pcxrle_dp.sv
module pcxrle_dp
  import pcxrle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  in_beat_t    in_data,
  output out_beat_t   out_data,
  output logic        out_valid,
  input  logic        out_ready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  cmd_t        cmd,
  output sts_t        sts
);

  logic [15:0] width_q, height_q, stride_q;
  logic [31:0] total_q;
  logic        cfg_busy;

  logic [15:0] column;
  logic [31:0] emitted;
  logic [5:0]  pend_len;
  logic        awaiting;

  logic [7:0]  byte_q;
  logic        last_q;
  logic [5:0]  run_left;
  logic [7:0]  run_val;

  logic        done, marker;
  logic [5:0]  byte_count;
  logic        visible, wrap, complete, load;
  logic [15:0] col_inc;
  logic [31:0] emitted_inc;

  assign cfg_ready = 1'b1;

  // config registers; total is re-registered, so input is held off in the cycle after a write
  always_ff @(posedge clk) begin
    if (rst) begin
      width_q  <= 16'd1;
      height_q <= 16'd1;
      stride_q <= 16'd1;
      total_q  <= 32'd1;
      cfg_busy <= 1'b0;
    end else begin
      total_q  <= 32'(width_q) * 32'(height_q);
      cfg_busy <= cfg_valid;
      if (cfg_valid) begin
        case (cfg_index)
          REG_WIDTH:  width_q  <= cfg_data;
          REG_HEIGHT: height_q <= cfg_data;
          REG_STRIDE: stride_q <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  assign done       = (emitted >= total_q);
  assign marker     = (byte_q >= MARKER_BASE);
  assign byte_count = 6'(byte_q & COUNT_MASK);

  assign col_inc     = column + 16'd1;
  assign emitted_inc = emitted + 32'd1;
  assign visible     = (column < width_q) && (emitted < total_q);
  assign wrap        = (col_inc >= stride_q);
  assign complete    = (emitted_inc == total_q);
  assign load        = cmd.step && visible;

  assign sts.cfg_busy     = cfg_busy;
  assign sts.step_blocked = visible && out_valid && !out_ready;
  assign sts.step_final   = (run_left == 6'd1) || wrap;
  assign sts.dec_emit     = !done &&
                            (awaiting ? (pend_len != 6'd0) :
                             marker   ? (last_q && byte_count != 6'd0) : 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      column   <= '0;
      emitted  <= '0;
      pend_len <= '0;
      awaiting <= 1'b0;
    end else if (cmd.accept) begin
      if (in_data.start_of_image) begin
        column   <= '0;
        emitted  <= '0;
        pend_len <= '0;
        awaiting <= 1'b0;
      end
    end else if (cmd.decide) begin
      if (!done && !awaiting && marker && !last_q) begin
        pend_len <= byte_count;
        awaiting <= 1'b1;
      end else if (!done) begin
        awaiting <= 1'b0;
      end
    end else if (cmd.step) begin
      column <= wrap ? 16'd0 : col_inc;
      if (visible) emitted <= emitted_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_q <= in_data.coded_byte;
      last_q <= in_data.end_of_data;
    end
    if (cmd.decide) begin
      if (awaiting) begin
        run_left <= pend_len;
        run_val  <= byte_q;
      end else if (marker) begin
        run_left <= byte_count;
        run_val  <= 8'd0;
      end else begin
        run_left <= 6'd1;
        run_val  <= byte_q;
      end
    end else if (cmd.step) begin
      run_left <= run_left - 6'd1;
    end
  end

  // output register; each step of the run shows a pixel only if column and count allow
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.pixel_value    <= run_val;
      out_data.last_of_burst  <= sts.step_final || (col_inc >= width_q) || complete;
      out_data.image_complete <= complete;
    end
  end

  a_step_not_blocked: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !sts.step_blocked)
    else $error("step taken while output register is full");

  a_step_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> run_left != 6'd0)
    else $error("step with empty run");

  a_complete_ends_burst: assert property (@(posedge clk) disable iff (rst)
    load && complete |=> out_valid && out_data.last_of_burst)
    else $error("image complete pixel not marked last of burst");

  a_no_accept_after_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> !cmd.accept)
    else $error("input beat taken before total settled");

endmodule

FILE: hdl/pcx_rle_line_decoder.sv
// PCX run-length decoder for 8-bit indexed images. One coded byte is taken per
// beat; a literal byte passes through accept, decode and emit, a marker waiting
// for its value byte through accept and decode, and a run through accept, decode
// and an emit step per run position (up to 63 or a stride wrap), hidden padding
// columns included, each visible step waiting while the output stalls. Pixels
// leave through a one-deep output register. Set image_width, image_height and
// line_stride_bytes only while idle; input is held off in the cycle after each
// config write while the pixel total is recomputed. Unknown indexes are ignored.
module pcx_rle_line_decoder
  import pcxrle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_beat_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  pcxrle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcxrle_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

FILE: test/pcx_rle_pixel_check.sv
module pcx_rle_pixel_check
  import pcxrle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_beat_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_beat_t   out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          pixels_owed
);

  logic [15:0] width_r;
  logic [15:0] height_r;
  logic [15:0] stride_r;
  logic [15:0] column;
  logic [31:0] emitted;
  logic [5:0]  held_count;
  logic        value_due;

  out_beat_t   owed_pixels[$];
  out_beat_t   want;

  // Walk a run across the line; columns past the width are hidden, and the
  // run stops where the column wraps at the stride.
  task automatic expand_run(input logic [5:0] count, input logic [7:0] value);
    logic [31:0] total;
    out_beat_t   px;
    logic        have_px;
    total   = {16'd0, width_r} * {16'd0, height_r};
    have_px = 1'b0;
    px      = '0;
    for (int r = 0; r < count; r++) begin
      if (column < width_r && emitted < total) begin
        if (have_px)
          owed_pixels.push_back(px);
        emitted            = emitted + 1;
        px.pixel_value     = value;
        px.last_of_burst   = 1'b0;
        px.image_complete  = (emitted == total);
        have_px            = 1'b1;
      end
      column = column + 16'd1;
      if (column >= stride_r) begin
        column = '0;
        break;
      end
    end
    if (have_px) begin
      px.last_of_burst = 1'b1;
      owed_pixels.push_back(px);
    end
  endtask

  task automatic decode_byte(input in_beat_t b);
    logic [31:0] total;
    logic [7:0]  masked;
    if (b.start_of_image) begin
      column     = '0;
      emitted    = '0;
      held_count = '0;
      value_due  = 1'b0;
    end
    total  = {16'd0, width_r} * {16'd0, height_r};
    masked = b.coded_byte & COUNT_MASK;
    if (emitted < total) begin
      if (value_due) begin
        value_due = 1'b0;
        expand_run(held_count, b.coded_byte);
      end else if (b.coded_byte >= MARKER_BASE) begin
        // a marker on the last beat has no value byte to follow: run of zeros
        if (b.end_of_data) begin
          expand_run(masked[5:0], 8'd0);
        end else begin
          held_count = masked[5:0];
          value_due  = 1'b1;
        end
      end else begin
        expand_run(6'd1, b.coded_byte);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_r        = 16'd1;
      height_r       = 16'd1;
      stride_r       = 16'd1;
      column         = '0;
      emitted        = '0;
      held_count     = '0;
      value_due      = 1'b0;
      mismatch_count = 0;
      owed_pixels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WIDTH:  width_r  = cfg_data;
          REG_HEIGHT: height_r = cfg_data;
          REG_STRIDE: stride_r = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        decode_byte(in_data);
      if (out_valid && out_ready) begin
        if (owed_pixels.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected pixel beat: value %h last %b complete %b",
                   $time, out_data.pixel_value, out_data.last_of_burst,
                   out_data.image_complete);
        end else begin
          want = owed_pixels.pop_front();
          if (out_data.pixel_value !== want.pixel_value ||
              out_data.last_of_burst !== want.last_of_burst ||
              out_data.image_complete !== want.image_complete) begin
            mismatch_count++;
            $display("%0t: pixel mismatch: expected %h/%b/%b, got %h/%b/%b",
                     $time, want.pixel_value, want.last_of_burst,
                     want.image_complete, out_data.pixel_value,
                     out_data.last_of_burst, out_data.image_complete);
          end
        end
      end
    end
    pixels_owed <= owed_pixels.size();
  end

endmodule

FILE: test/pcx_rle_line_decoder_tb.sv
module pcx_rle_line_decoder_tb;
  import pcxrle_pkg::*;

  localparam logic [1:0] REG_SPARE     = 2'd3;
  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         SETTLE_CYCLES = 150;
  localparam int         BYTES_PER_SETTING = 32;

  logic        clk;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_beat_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  int mismatch_count;
  int pixels_owed;
  int idle_pct    = 28;
  int stall_pct   = 73;
  int bytes_sent  = 0;
  int cycle_count = 0;

  pcx_rle_line_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pcx_rle_pixel_check u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pixels_owed    (pixels_owed)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pcx_rle_line_decoder regression: fail");
      $finish;
    end
  end

  // valid stays high after a beat; settle or a random idle gap before the next beat drops it
  task automatic send_byte(input logic [7:0] value, input logic sof, input logic eod);
    in_beat_t b;
    b.coded_byte     = value;
    b.start_of_image = sof;
    b.end_of_data    = eod;
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // marker bytes and ignored bytes leave no pixel behind, so wait out the
  // longest run after the last owed pixel
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pixels_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] w, input logic [15:0] h,
                           input logic [15:0] s);
    settle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_STRIDE, s);
    write_reg(REG_SPARE, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed: literals and marker/value pairs, last usually with end_of_data
  task automatic send_image(input int n_items);
    int k;
    int kind;
    logic sof;
    logic eod;
    for (k = 0; k < n_items; k++) begin
      sof  = (k == 0);
      eod  = (k == n_items - 1);
      kind = $urandom_range(99);
      if (kind < 50) begin
        send_byte(8'($urandom_range(191)), sof, eod);
      end else if (kind < 88) begin
        send_byte(MARKER_BASE | 8'($urandom_range(63)), sof, eod);
        if (!eod) begin
          k++;
          send_byte(8'($urandom_range(255)), 1'b0, k == n_items - 1);
        end
      end else begin
        send_byte(8'($urandom_range(255)), $urandom_range(9) == 0,
                  $urandom_range(9) == 0);
      end
    end
  endtask

  initial begin
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] s;
    int          bytes_goal;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // one-pixel image: second byte lands after completion
    configure(16'd1, 16'd1, 16'd1);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b0);

    configure(16'd6, 16'd3, 16'd8);
    send_byte(8'h00, 1'b1, 1'b0);
    send_byte(8'hBF, 1'b0, 1'b0);
    send_byte(MARKER_BASE, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(MARKER_BASE | COUNT_MASK, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(MARKER_BASE | 8'd3, 1'b0, 1'b0);
    send_byte(8'h55, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(MARKER_BASE | 8'd5, 1'b0, 1'b1);
    // start of image drops the pending marker
    send_byte(MARKER_BASE | 8'd4, 1'b1, 1'b0);
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(MARKER_BASE | COUNT_MASK, 1'b0, 1'b0);
    send_byte(MARKER_BASE, 1'b0, 1'b0);
    send_byte(MARKER_BASE | COUNT_MASK, 1'b0, 1'b0);
    send_byte(8'h3F, 1'b0, 1'b1);
    send_byte(8'h01, 1'b0, 1'b0);

    // zero width: everything ignored
    configure(16'd0, 16'd5, 16'd4);
    send_byte(8'h12, 1'b1, 1'b0);
    send_byte(MARKER_BASE | 8'd7, 1'b0, 1'b1);

    // zero stride: each run cut to one pixel
    configure(16'd5, 16'd3, 16'd0);
    send_byte(MARKER_BASE | 8'd9, 1'b1, 1'b0);
    send_byte(8'h44, 1'b0, 1'b0);
    send_byte(8'h21, 1'b0, 1'b0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin idle_pct = 28; stall_pct = 73; end
        1: begin idle_pct = 73; stall_pct = 28; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      for (int setting = 0; setting < 3; setting++) begin
        w = 16'($urandom_range(1, 64));
        h = 16'($urandom_range(1, 40));
        if ($urandom_range(3) == 0)
          s = 16'($urandom_range(1, w));
        else
          s = w + 16'($urandom_range(0, 6));
        if (phase == 0 && setting == 0) begin
          w = 16'hFFFF; h = 16'hFFFF; s = 16'hFFFF;
        end else if (phase == 1 && setting == 1) begin
          w = 16'hFFFF; h = 16'd1; s = 16'd40;
        end
        configure(w, h, s);
        bytes_goal = bytes_sent + BYTES_PER_SETTING;
        while (bytes_sent < bytes_goal)
          send_image($urandom_range(4, 30));
      end
    end

    settle();
    if (mismatch_count == 0 && pixels_owed == 0)
      $display("pcx_rle_line_decoder regression: pass");
    else
      $display("pcx_rle_line_decoder regression: fail");
    $finish;
  end

endmodule
